[hdl/cfs_pkg.sv]
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the control-flow sequencer.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int unsigned KindW = 4;

  typedef enum logic [KindW-1:0] {
    K_BCC     = 4'd0,
    K_BRA     = 4'd1,
    K_BRL     = 4'd2,
    K_JMP     = 4'd3,
    K_JML     = 4'd4,
    K_JMP_IND = 4'd5,
    K_JMP_IX  = 4'd6,
    K_JML_IND = 4'd7,
    K_JSR     = 4'd8,
    K_JSL     = 4'd9,
    K_JSR_IX  = 4'd10,
    K_RTI     = 4'd11,
    K_RTS     = 4'd12,
    K_RTL     = 4'd13
  } kind_t;

  localparam logic [1:0] ACC_READ   = 2'd0;
  localparam logic [1:0] ACC_WRITE  = 2'd1;
  localparam logic [1:0] ACC_FINISH = 2'd2;

  localparam logic [7:0] EMU_STATUS_OR  = 8'h30;
  localparam logic [7:0] EMU_STACK_PAGE = 8'h01;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        mode;
    logic [3:0]  instr_kind;
    logic        branch_taken;
    logic [23:0] pc_in;
    logic [15:0] sp_in;
    logic [15:0] index_x;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  access;
    logic [23:0] address;
    logic [7:0]  write_data;
    logic [23:0] new_pc;
    logic [15:0] new_sp;
    logic [7:0]  new_status;
    logic        status_valid;
    logic        clear_index_high;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_slot_t;

endpackage

[hdl/cfs_if.sv]
// ----------------------------------------------------------------------------
// cfs_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface cfs_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/cfs_front.sv]
// ----------------------------------------------------------------------------
// cfs_front
// Executes the sequencing of one input transaction combinationally and
// produces up to three results at once, which are pushed into the queue.
// ----------------------------------------------------------------------------
module cfs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                emu,
  input  logic                fire,
  input  cfs_pkg::in_item_t   item,
  output cfs_pkg::res_slot_t  res0,
  output cfs_pkg::res_slot_t  res1,
  output cfs_pkg::res_slot_t  res2
);
  import cfs_pkg::*;

  logic [3:0]  step_r, step_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [23:0] pc_r, pc_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] x_r, x_nxt;
  logic [23:0] opw_r, opw_nxt;
  logic [23:0] dw_r, dw_nxt;
  logic [7:0]  st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0; kind_r <= '0; pc_r <= '0; sp_r <= '0;
      x_r <= '0; opw_r <= '0; dw_r <= '0; st_r <= '0;
    end else if (fire) begin
      step_r <= step_nxt; kind_r <= kind_nxt; pc_r <= pc_nxt; sp_r <= sp_nxt;
      x_r <= x_nxt; opw_r <= opw_nxt; dw_r <= dw_nxt; st_r <= st_nxt;
    end
  end

  always_comb begin
    logic [1:0]  n;
    logic [7:0]  d;
    logic [15:0] base;
    logic [15:0] t16;
    logic [23:0] bank;
    out_item_t   r [3];
    logic        fin;
    logic        with_st;
    step_nxt = step_r; kind_nxt = kind_r; pc_nxt = pc_r; sp_nxt = sp_r;
    x_nxt = x_r; opw_nxt = opw_r; dw_nxt = dw_r; st_nxt = st_r;
    n = 2'd0; d = item.read_data; fin = 1'b0; with_st = 1'b0;
    base = '0; t16 = '0; bank = '0;
    for (int i = 0; i < 3; i++) r[i] = '0;

    // Bus access helpers are written out inline in the code below.
    if (!item.mode) begin
      pc_nxt = item.pc_in; sp_nxt = item.sp_in; x_nxt = item.index_x;
      opw_nxt = '0; dw_nxt = '0; st_nxt = '0;
      kind_nxt = (item.instr_kind == K_BCC) ? {3'b0, item.branch_taken}
                                            : item.instr_kind;
      step_nxt = 4'd1;
      if (item.instr_kind <= K_JSR_IX) begin
        r[0].access = ACC_READ; r[0].address = pc_nxt;
        pc_nxt[15:0] = pc_nxt[15:0] + 16'd1; n = 2'd1;
      end else if (item.instr_kind == K_RTI || item.instr_kind == K_RTS) begin
        if (emu) begin
          sp_nxt[7:0] = sp_nxt[7:0] + 8'd1;
          r[0].address = {16'h0001, sp_nxt[7:0]};
        end else begin
          sp_nxt = sp_nxt + 16'd1; r[0].address = {8'h0, sp_nxt};
        end
        r[0].access = ACC_READ; n = 2'd1;
      end else if (item.instr_kind == K_RTL) begin
        sp_nxt = sp_nxt + 16'd1; r[0].address = {8'h0, sp_nxt};
        r[0].access = ACC_READ; n = 2'd1;
      end else begin
        fin = 1'b1;
      end
    end else if (step_r != 4'd0) begin
      step_nxt = step_r + 4'd1;
      case (kind_r)
        K_BCC: fin = 1'b1;
        K_BRA: begin
          pc_nxt[15:0] = pc_r[15:0] + {{8{d[7]}}, d}; fin = 1'b1;
        end
        K_BRL, K_JMP: begin
          if (step_r == 4'd1) begin
            dw_nxt = {16'h0, d};
            r[0].access = ACC_READ; r[0].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd1;
          end else begin
            pc_nxt[15:0] = (kind_r == K_BRL) ? pc_r[15:0] + {d, dw_r[7:0]}
                                             : {d, dw_r[7:0]};
            fin = 1'b1;
          end
        end
        K_JML: begin
          if (step_r == 4'd1 || step_r == 4'd2) begin
            if (step_r == 4'd1) dw_nxt = {16'h0, d};
            else dw_nxt = {8'h0, d, dw_r[7:0]};
            r[0].access = ACC_READ; r[0].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd1;
          end else begin
            pc_nxt = {d, dw_r[15:0]}; fin = 1'b1;
          end
        end
        K_JMP_IND, K_JMP_IX, K_JML_IND: begin
          bank = (kind_r == K_JMP_IX) ? {pc_r[23:16], 16'h0} : 24'h0;
          base = (kind_r == K_JMP_IX) ? opw_r[15:0] + x_r : opw_r[15:0];
          if (step_r == 4'd1) begin
            opw_nxt = {16'h0, d};
            r[0].access = ACC_READ; r[0].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd1;
          end else if (step_r == 4'd2) begin
            opw_nxt = {8'h0, d, opw_r[7:0]};
            base = (kind_r == K_JMP_IX) ? opw_nxt[15:0] + x_r : opw_nxt[15:0];
            r[0].access = ACC_READ; r[0].address = bank | {8'h0, base}; n = 2'd1;
          end else if (step_r == 4'd3) begin
            dw_nxt = {16'h0, d};
            t16 = base + 16'd1;
            r[0].access = ACC_READ; r[0].address = bank | {8'h0, t16}; n = 2'd1;
          end else if (step_r == 4'd4 && kind_r == K_JML_IND) begin
            dw_nxt = {8'h0, d, dw_r[7:0]};
            t16 = base + 16'd2;
            r[0].access = ACC_READ; r[0].address = {8'h0, t16}; n = 2'd1;
          end else begin
            if (kind_r == K_JML_IND) pc_nxt = {d, dw_r[15:0]};
            else pc_nxt[15:0] = {d, dw_r[7:0]};
            fin = 1'b1;
          end
        end
        K_JSR: begin
          if (step_r == 4'd1) begin
            opw_nxt = {16'h0, d};
            r[0].access = ACC_READ; r[0].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd1;
          end else begin
            opw_nxt = {8'h0, d, opw_r[7:0]};
            t16 = pc_r[15:0] - 16'd1;
            for (int i = 0; i < 2; i++) begin
              r[i].access = ACC_WRITE;
              r[i].write_data = (i == 0) ? t16[15:8] : t16[7:0];
              if (emu) begin
                r[i].address = {16'h0001, sp_nxt[7:0]};
                sp_nxt[7:0] = sp_nxt[7:0] - 8'd1;
              end else begin
                r[i].address = {8'h0, sp_nxt};
                sp_nxt = sp_nxt - 16'd1;
              end
            end
            n = 2'd2;
            pc_nxt[15:0] = opw_nxt[15:0]; fin = 1'b1;
          end
        end
        K_JSL: begin
          if (step_r == 4'd1) begin
            opw_nxt = {16'h0, d};
            r[0].access = ACC_READ; r[0].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd1;
          end else if (step_r == 4'd2) begin
            opw_nxt = {8'h0, d, opw_r[7:0]};
            r[0].access = ACC_WRITE; r[0].address = {8'h0, sp_r};
            r[0].write_data = pc_r[23:16]; sp_nxt = sp_r - 16'd1;
            r[1].access = ACC_READ; r[1].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd2;
          end else begin
            t16 = pc_r[15:0] - 16'd1;
            r[0].access = ACC_WRITE; r[0].address = {8'h0, sp_r};
            r[0].write_data = t16[15:8];
            r[1].access = ACC_WRITE; r[1].address = {8'h0, sp_r - 16'd1};
            r[1].write_data = t16[7:0];
            sp_nxt = sp_r - 16'd2; n = 2'd2;
            pc_nxt = {d, opw_r[15:0]};
            if (emu) sp_nxt[15:8] = EMU_STACK_PAGE;
            fin = 1'b1;
          end
        end
        K_JSR_IX: begin
          if (step_r == 4'd1) begin
            opw_nxt = {16'h0, d};
            r[0].access = ACC_WRITE; r[0].address = {8'h0, sp_r};
            r[0].write_data = pc_r[15:8];
            r[1].access = ACC_WRITE; r[1].address = {8'h0, sp_r - 16'd1};
            r[1].write_data = pc_r[7:0];
            sp_nxt = sp_r - 16'd2;
            r[2].access = ACC_READ; r[2].address = pc_r;
            pc_nxt[15:0] = pc_r[15:0] + 16'd1; n = 2'd3;
          end else if (step_r == 4'd2) begin
            opw_nxt = {8'h0, d, opw_r[7:0]};
            t16 = opw_nxt[15:0] + x_r;
            r[0].access = ACC_READ; r[0].address = {pc_r[23:16], t16}; n = 2'd1;
          end else if (step_r == 4'd3) begin
            dw_nxt = {16'h0, d};
            t16 = opw_r[15:0] + x_r + 16'd1;
            r[0].access = ACC_READ; r[0].address = {pc_r[23:16], t16}; n = 2'd1;
          end else begin
            pc_nxt[15:0] = {d, dw_r[7:0]};
            if (emu) sp_nxt[15:8] = EMU_STACK_PAGE;
            fin = 1'b1;
          end
        end
        K_RTI: begin
          with_st = 1'b0;
          if (step_r == 4'd1 || step_r == 4'd2 || (step_r == 4'd3 && !emu)) begin
            if (step_r == 4'd1) st_nxt = emu ? (d | EMU_STATUS_OR) : d;
            else if (step_r == 4'd2) dw_nxt = {16'h0, d};
            else dw_nxt = {8'h0, d, dw_r[7:0]};
            if (emu) begin
              sp_nxt[7:0] = sp_r[7:0] + 8'd1;
              r[0].address = {16'h0001, sp_nxt[7:0]};
            end else begin
              sp_nxt = sp_r + 16'd1; r[0].address = {8'h0, sp_nxt};
            end
            r[0].access = ACC_READ; n = 2'd1;
          end else begin
            if (step_r == 4'd3) pc_nxt[15:0] = {d, dw_r[7:0]};
            else pc_nxt = {d, dw_r[15:0]};
            fin = 1'b1; with_st = 1'b1;
          end
        end
        K_RTS: begin
          if (step_r == 4'd1) begin
            dw_nxt = {16'h0, d};
            if (emu) begin
              sp_nxt[7:0] = sp_r[7:0] + 8'd1;
              r[0].address = {16'h0001, sp_nxt[7:0]};
            end else begin
              sp_nxt = sp_r + 16'd1; r[0].address = {8'h0, sp_nxt};
            end
            r[0].access = ACC_READ; n = 2'd1;
          end else begin
            pc_nxt[15:0] = {d, dw_r[7:0]} + 16'd1; fin = 1'b1;
          end
        end
        K_RTL: begin
          if (step_r == 4'd1 || step_r == 4'd2) begin
            if (step_r == 4'd1) dw_nxt = {16'h0, d};
            else dw_nxt = {8'h0, d, dw_r[7:0]};
            sp_nxt = sp_r + 16'd1; r[0].address = {8'h0, sp_nxt};
            r[0].access = ACC_READ; n = 2'd1;
          end else begin
            t16 = dw_r[15:0] + 16'd1;
            pc_nxt = {d, t16};
            if (emu) sp_nxt[15:8] = EMU_STACK_PAGE;
            fin = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
    end

    if (fin) begin
      r[n].access = ACC_FINISH;
      r[n].new_pc = pc_nxt;
      r[n].new_sp = sp_nxt;
      if (with_st) begin
        r[n].new_status = st_nxt;
        r[n].status_valid = 1'b1;
        r[n].clear_index_high = !emu && st_nxt[4];
      end
      n = n + 2'd1;
      step_nxt = 4'd0;
    end
    if (n != 2'd0) r[n - 2'd1].last = 1'b1;

    res0 = '{valid: (n > 2'd0), item: r[0]};
    res1 = '{valid: (n > 2'd1), item: r[1]};
    res2 = '{valid: (n > 2'd2), item: r[2]};
  end

endmodule

[hdl/cfs_queue.sv]
// ----------------------------------------------------------------------------
// cfs_queue
// Result queue taking up to three results per cycle, giving one when ready.
// ----------------------------------------------------------------------------
module cfs_queue #(
  parameter int unsigned DEPTH = cfs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cfs_pkg::res_slot_t res0,
  input  cfs_pkg::res_slot_t res1,
  input  cfs_pkg::res_slot_t res2,
  output logic               can_take,
  cfs_if.source              out_ch
);
  import cfs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  out_item_t          mem_r [DEPTH];
  logic [AW-1:0]      rd_r, wr_r;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic [1:0]         n_in;
  logic               pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != '0;
  assign out_ch.data  = mem_r[rd_r];
  assign can_take = (cnt_r + (AW+1)'(3)) <= (AW+1)'(DEPTH);
  assign n_in = push ? {1'b0, res0.valid} + {1'b0, res1.valid} + {1'b0, res2.valid}
                     : 2'd0;
  assign cnt_nxt = cnt_r + (AW+1)'(n_in) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_r + AW'(n_in);
      if (pop) rd_r <= rd_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && res0.valid) mem_r[wr_r] <= res0.item;
    if (push && res1.valid) mem_r[wr_r + AW'(1)] <= res1.item;
    if (push && res2.valid) mem_r[wr_r + AW'(2)] <= res2.item;
  end

endmodule

[hdl/cpu_control_flow_sequencer.sv]
// ----------------------------------------------------------------------------
// cpu_control_flow_sequencer
// Bus-access sequencer for 65816 branch, jump, call and return instructions.
// ----------------------------------------------------------------------------
// Usage: a start transaction on the input channel (mode 0) carries the
// instruction kind, PC, S and X; each read reply (mode 1) carries the byte
// for the last read request. Every input transaction yields up to three
// result transactions (reads, writes, finish) on the output channel, the
// final one marked by last.
// The front part decodes a transaction in the cycle it is accepted and
// pushes its results into a four-entry queue, which offers them in order;
// results leave one per cycle while the receiver is ready. One input
// transaction is accepted per cycle while the queue has room for three
// results, so a stalled receiver holds off input after at most four
// buffered results. The register emulation_mode sits at address 0 of the
// cfg port and resets to 1. Reset empties the queue and returns the
// sequencer to idle; there is no clearing pass.
// ----------------------------------------------------------------------------
module cpu_control_flow_sequencer #(
  parameter int unsigned QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  cfs_if.sink         in_ch,
  cfs_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cfs_pkg::*;

  logic      emu_r;
  logic      can_take;
  logic      fire;
  res_slot_t res0, res1, res2;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'h0, emu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emu_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
      emu_r <= cfg_pwdata[0];
    end
  end

  assign in_ch.ready = can_take;
  assign fire = in_ch.valid && in_ch.ready;

  cfs_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .emu  (emu_r),
    .fire (fire),
    .item (in_ch.data),
    .res0 (res0),
    .res1 (res1),
    .res2 (res2)
  );

  cfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fire),
    .res0    (res0),
    .res1    (res1),
    .res2    (res2),
    .can_take(can_take),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.access == ACC_FINISH |-> out_ch.data.last)
    else $error("finish transaction not marked last");
  a_status_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status_valid |-> out_ch.data.access == ACC_FINISH)
    else $error("status on a bus request");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule

[sim/cfs_checker.sv]
// ----------------------------------------------------------------------------
// cfs_checker
// Watches the input, result and cfg ports of the control-flow sequencer,
// predicts the bus accesses and finish reports of every accepted input
// transaction and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cfs_checker
  import cfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [31:0] cfg_pwdata,
  output int          pending,
  output int          fail_count
);

  out_item_t   bus_q[$];
  logic        emu;
  logic [3:0]  step;
  logic [3:0]  kind_hold;
  logic [23:0] pc_w;
  logic [15:0] sp_w;
  logic [15:0] x_hold;
  logic [23:0] oper_w;
  logic [23:0] data_w;
  logic [7:0]  stat_w;

  assign pending = bus_q.size();

  function automatic void emit(logic [1:0] acc, logic [23:0] addr, logic [7:0] wd);
    out_item_t r;
    r = '0;
    r.access = acc;
    r.address = addr;
    r.write_data = wd;
    bus_q.push_back(r);
  endfunction

  function automatic void finish_instr(logic with_status);
    out_item_t r;
    r = '0;
    r.access = ACC_FINISH;
    r.new_pc = pc_w;
    r.new_sp = sp_w;
    if (with_status) begin
      r.new_status = stat_w;
      r.status_valid = 1'b1;
      r.clear_index_high = !emu && stat_w[4];
    end
    bus_q.push_back(r);
    step = 4'd0;
  endfunction

  function automatic void set_pc16(logic [15:0] w);
    pc_w[15:0] = w;
  endfunction

  function automatic void fetch_pc();
    logic [23:0] a;
    a = pc_w;
    pc_w[15:0] = pc_w[15:0] + 16'd1;
    emit(ACC_READ, a, 8'h00);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic page);
    logic [23:0] a;
    if (page && emu) begin
      a = {16'h0001, sp_w[7:0]};
      sp_w[7:0] = sp_w[7:0] - 8'd1;
    end else begin
      a = {8'h00, sp_w};
      sp_w = sp_w - 16'd1;
    end
    emit(ACC_WRITE, a, b);
  endfunction

  function automatic void pull_byte(logic page);
    if (page && emu) begin
      sp_w[7:0] = sp_w[7:0] + 8'd1;
      emit(ACC_READ, {16'h0001, sp_w[7:0]}, 8'h00);
    end else begin
      sp_w = sp_w + 16'd1;
      emit(ACC_READ, {8'h00, sp_w}, 8'h00);
    end
  endfunction

  function automatic void force_stack_page();
    if (emu) sp_w[15:8] = EMU_STACK_PAGE;
  endfunction

  function automatic void start_instr(in_item_t it);
    pc_w = it.pc_in;
    sp_w = it.sp_in;
    x_hold = it.index_x;
    oper_w = '0;
    data_w = '0;
    stat_w = '0;
    kind_hold = (it.instr_kind == K_BCC) ? {3'b000, it.branch_taken} : it.instr_kind;
    step = 4'd1;
    if (it.instr_kind <= K_JSR_IX) fetch_pc();
    else if (it.instr_kind == K_RTI || it.instr_kind == K_RTS) pull_byte(1'b1);
    else if (it.instr_kind == K_RTL) pull_byte(1'b0);
    else finish_instr(1'b0);
  endfunction

  function automatic void reply_byte(logic [7:0] d);
    logic [3:0]  s;
    logic [15:0] base;
    logic [7:0]  bank;
    s = step;
    step = s + 4'd1;
    case (kind_t'(kind_hold))
      K_BCC: finish_instr(1'b0);
      K_BRA: begin
        set_pc16(pc_w[15:0] + {{8{d[7]}}, d});
        finish_instr(1'b0);
      end
      K_BRL: begin
        if (s == 4'd1) begin
          data_w = {16'h0, d};
          fetch_pc();
        end else begin
          set_pc16(pc_w[15:0] + {d, data_w[7:0]});
          finish_instr(1'b0);
        end
      end
      K_JMP: begin
        if (s == 4'd1) begin
          data_w = {16'h0, d};
          fetch_pc();
        end else begin
          set_pc16({d, data_w[7:0]});
          finish_instr(1'b0);
        end
      end
      K_JML: begin
        if (s == 4'd1) begin
          data_w = {16'h0, d};
          fetch_pc();
        end else if (s == 4'd2) begin
          data_w[15:8] = d;
          fetch_pc();
        end else begin
          pc_w = {d, data_w[15:0]};
          finish_instr(1'b0);
        end
      end
      K_JMP_IND, K_JMP_IX, K_JML_IND: begin
        bank = (kind_hold == K_JMP_IX) ? pc_w[23:16] : 8'h00;
        if (s == 4'd1) begin
          oper_w = {16'h0, d};
          fetch_pc();
        end else begin
          if (s == 4'd2) oper_w[15:8] = d;
          base = (kind_hold == K_JMP_IX) ? oper_w[15:0] + x_hold : oper_w[15:0];
          if (s == 4'd2) begin
            emit(ACC_READ, {bank, base}, 8'h00);
          end else if (s == 4'd3) begin
            data_w = {16'h0, d};
            emit(ACC_READ, {bank, base + 16'd1}, 8'h00);
          end else if (s == 4'd4 && kind_hold == K_JML_IND) begin
            data_w[15:8] = d;
            emit(ACC_READ, {8'h00, base + 16'd2}, 8'h00);
          end else begin
            if (kind_hold == K_JML_IND) pc_w = {d, data_w[15:0]};
            else set_pc16({d, data_w[7:0]});
            finish_instr(1'b0);
          end
        end
      end
      K_JSR: begin
        if (s == 4'd1) begin
          oper_w = {16'h0, d};
          fetch_pc();
        end else begin
          oper_w[15:8] = d;
          set_pc16(pc_w[15:0] - 16'd1);
          push_byte(pc_w[15:8], 1'b1);
          push_byte(pc_w[7:0], 1'b1);
          set_pc16(oper_w[15:0]);
          finish_instr(1'b0);
        end
      end
      K_JSL: begin
        if (s == 4'd1) begin
          oper_w = {16'h0, d};
          fetch_pc();
        end else if (s == 4'd2) begin
          oper_w[15:8] = d;
          push_byte(pc_w[23:16], 1'b0);
          fetch_pc();
        end else begin
          oper_w[23:16] = d;
          set_pc16(pc_w[15:0] - 16'd1);
          push_byte(pc_w[15:8], 1'b0);
          push_byte(pc_w[7:0], 1'b0);
          pc_w = oper_w;
          force_stack_page();
          finish_instr(1'b0);
        end
      end
      K_JSR_IX: begin
        if (s == 4'd1) begin
          oper_w = {16'h0, d};
          push_byte(pc_w[15:8], 1'b0);
          push_byte(pc_w[7:0], 1'b0);
          fetch_pc();
        end else if (s == 4'd2) begin
          oper_w[15:8] = d;
          emit(ACC_READ, {pc_w[23:16], oper_w[15:0] + x_hold}, 8'h00);
        end else if (s == 4'd3) begin
          data_w = {16'h0, d};
          emit(ACC_READ, {pc_w[23:16], oper_w[15:0] + x_hold + 16'd1}, 8'h00);
        end else begin
          set_pc16({d, data_w[7:0]});
          force_stack_page();
          finish_instr(1'b0);
        end
      end
      K_RTI: begin
        if (s == 4'd1) begin
          stat_w = emu ? (d | EMU_STATUS_OR) : d;
          pull_byte(1'b1);
        end else if (s == 4'd2) begin
          data_w = {16'h0, d};
          pull_byte(1'b1);
        end else if (s == 4'd3) begin
          data_w[15:8] = d;
          if (emu) begin
            set_pc16(data_w[15:0]);
            finish_instr(1'b1);
          end else begin
            pull_byte(1'b1);
          end
        end else begin
          pc_w = {d, data_w[15:0]};
          finish_instr(1'b1);
        end
      end
      K_RTS: begin
        if (s == 4'd1) begin
          data_w = {16'h0, d};
          pull_byte(1'b1);
        end else begin
          set_pc16({d, data_w[7:0]} + 16'd1);
          finish_instr(1'b0);
        end
      end
      K_RTL: begin
        if (s == 4'd1) begin
          data_w = {16'h0, d};
          pull_byte(1'b0);
        end else if (s == 4'd2) begin
          data_w[15:8] = d;
          pull_byte(1'b0);
        end else begin
          pc_w = {d, data_w[15:0] + 16'd1};
          force_stack_page();
          finish_instr(1'b0);
        end
      end
      default: finish_instr(1'b0);
    endcase
  endfunction

  function automatic void predict(in_item_t it);
    int        n0;
    out_item_t r;
    n0 = bus_q.size();
    if (!it.mode) start_instr(it);
    else if (step != 4'd0) reply_byte(it.read_data);
    if (bus_q.size() > n0) begin
      r = bus_q.pop_back();
      r.last = 1'b1;
      bus_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      emu <= 1'b1;
      step = 4'd0;
      kind_hold = '0;
      pc_w = '0;
      sp_w = '0;
      x_hold = '0;
      oper_w = '0;
      data_w = '0;
      stat_w = '0;
      bus_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = bus_q.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10) begin
              $display({"result mismatch: expected acc %0d addr %h wd %h pc %h",
                        " sp %h st %h sv %b ci %b last %b"},
                       want.access, want.address, want.write_data, want.new_pc,
                       want.new_sp, want.new_status, want.status_valid,
                       want.clear_index_high, want.last);
              $display({"                   actual acc %0d addr %h wd %h pc %h",
                        " sp %h st %h sv %b ci %b last %b"},
                       out_data.access, out_data.address, out_data.write_data,
                       out_data.new_pc, out_data.new_sp, out_data.new_status,
                       out_data.status_valid, out_data.clear_index_high,
                       out_data.last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict(in_data);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) emu <= cfg_pwdata[0];
    end
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives start and read-reply transactions into the control-flow sequencer,
// mostly as complete instruction sequences with random operands, under
// several idling patterns and both stack modes, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cfs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic        cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          pending;
  int          fail_count;
  int          send_idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  logic        emu_set;

  cfs_if #(.payload_t(in_item_t))  in_ch(clk);
  cfs_if #(.payload_t(out_item_t)) out_ch(clk);

  cpu_control_flow_sequencer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  cfs_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_pwdata(cfg_pwdata),
    .pending(pending), .fail_count(fail_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 1'b0;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    emu_set = v;
    @(posedge clk);
  endtask

  function automatic int replies_for(logic [3:0] k);
    case (k)
      K_BCC, K_BRA: return 1;
      K_BRL, K_JMP, K_JSR, K_RTS: return 2;
      K_JML, K_JSL, K_RTL: return 3;
      K_JMP_IND, K_JMP_IX, K_JSR_IX: return 4;
      K_JML_IND: return 5;
      K_RTI: return emu_set ? 3 : 4;
      default: return 0;
    endcase
  endfunction

  task automatic run_instr(logic [3:0] k, logic [23:0] pc, logic [15:0] sp,
                           logic [15:0] x, logic [7:0] fixed, logic rand_data);
    in_item_t    it;
    int          n;
    logic [95:0] raw;
    it = '0;
    it.mode = 1'b0;
    it.instr_kind = k;
    it.branch_taken = 1'($urandom_range(1));
    it.pc_in = pc;
    it.sp_in = sp;
    it.index_x = x;
    it.read_data = 8'($urandom);
    send(it);
    n = replies_for(k);
    if (rand_data && $urandom_range(99) < 12) n = int'($urandom_range(n));
    else if (rand_data && $urandom_range(99) < 10) n = n + 1;
    for (int i = 0; i < n; i++) begin
      raw = {$urandom, $urandom, $urandom};
      it = raw[$bits(in_item_t)-1:0];
      it.mode = 1'b1;
      it.read_data = rand_data ? 8'($urandom) : fixed;
      send(it);
    end
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(3))
      0: return 24'hffffff - 24'($urandom_range(3));
      1: return 24'($urandom_range(3));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0: return 16'hffff - 16'($urandom_range(3));
      1: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t    junk;
    logic [95:0] raw;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= 1'b0;
    cfg_pwdata <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    emu_set = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    junk = '0;
    junk.mode = 1'b1;
    send(junk);
    for (int k = 0; k < 16; k++) begin
      run_instr(4'(k), 24'hffffff, 16'h0000, 16'hffff, 8'hff, 1'b0);
    end
    wait_drained();
    write_mode(1'b0);
    for (int k = 0; k < 16; k++) begin
      run_instr(4'(k), 24'h000000, 16'hffff, 16'h0000, 8'h00, 1'b0);
    end
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int i = 0; i < 9; i++) begin
        if ($urandom_range(99) < 8) begin
          raw = {$urandom, $urandom, $urandom};
          junk = raw[$bits(in_item_t)-1:0];
          send(junk);
        end else begin
          run_instr(4'($urandom), pick24(), pick16(), pick16(), 8'h00, 1'b1);
        end
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
